FILE: hdl/per_port_droptail_output_queues_unit_defines.svh
// assertion macros for the per-port drop-tail output queue unit
// no dependencies; included by files that carry concurrent assertions
`ifndef PER_PORT_DROPTAIL_OUTPUT_QUEUES_UNIT_DEFINES_SVH
`define PER_PORT_DROPTAIL_OUTPUT_QUEUES_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PPDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPDQ_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PPDQ_ASSERT(label, clk, rst, prop, msg)
`define PPDQ_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: hdl/ppdq_pkg.sv
// shared constants, codes and payload types of the per-port drop-tail output queue unit
// no dependencies
package ppdq_pkg;

   localparam int NUM_PORTS   = 16;
   localparam int QUEUE_DEPTH = 64;
   localparam int TAG_WIDTH   = 16;

   localparam int TYPE_W     = 2;
   localparam int DEST_W     = 8;
   localparam int PORT_W     = 4;
   localparam int STAT_W     = 2;
   localparam int NODE_W     = 8;
   localparam int LIMIT_W    = 7;
   localparam int CSR_DATA_W = 8;

   localparam int PORT_IDX_W = $clog2(NUM_PORTS);
   localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_DEPTH  = NUM_PORTS * QUEUE_DEPTH;
   localparam int TAG_ADDR_W = $clog2(TAG_DEPTH);

   localparam logic [TYPE_W-1:0] REQ_SEND = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_RECV = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DONE = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_RSVD = 2'd3;

   localparam logic [STAT_W-1:0] STAT_ACCEPTED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LOCAL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DONE     = 2'd3;

   localparam logic CSR_NODE_ADDR   = 1'b0;
   localparam logic CSR_QUEUE_LIMIT = 1'b1;

   localparam logic [NODE_W-1:0]  NODE_ADDR_RESET   = 8'd0;
   localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic [TYPE_W-1:0]    req_type;
      logic [DEST_W-1:0]    dest_addr;
      logic [PORT_W-1:0]    next_port;
      logic [TAG_WIDTH-1:0] packet_tag;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic                 forward_valid;
      logic [PORT_W-1:0]    forward_port;
      logic [TAG_WIDTH-1:0] forward_tag;
   } rsp_payload_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] fill;
      logic [PTR_W-1:0] tail;
      logic [PTR_W-1:0] head;
   } ptr_entry_type;

   typedef struct packed {
      logic                  en;
      logic [PORT_IDX_W-1:0] addr;
      ptr_entry_type         data;
   } ptr_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_TAG_WAIT
   } ctrl_state_type;

endpackage

FILE: hdl/ppdq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ppdq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ppdq_ptr_table.sv
// per-port pointer table: head, tail, fill count and busy flag of each port queue
// depends on ppdq_pkg; entries never written read as zero through per-entry valid bits
module ppdq_ptr_table import ppdq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [PORT_IDX_W-1:0] rd_addr,
   output ptr_entry_type         rd_data,
   input  ptr_wr_type            wr
);

   ptr_entry_type        mem_ff [NUM_PORTS];
   logic [NUM_PORTS-1:0] valid_ff;
   ptr_entry_type        rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: hdl/per_port_droptail_output_queues_unit.sv
// per-port drop-tail output queues: pointer table, tag store and the control sequencer
// depends on ppdq_pkg, ppdq_ram, ppdq_ptr_table and the assertion macro header
//
//   channel  ports                        direction  transaction
//   req      req_valid req_ready req_data  in         send, receive or transmit-done event
//   rsp      rsp_valid rsp_ready rsp_data  out        status and optional forward of a tag
//   csr      csr_valid csr_ready csr_index in         write of node_addr or queue_limit
//            csr_data
//
// an event goes from accept to result through states: the accept cycle in idle reads the pointer table,
// lookup decides and writes back, and tag wait follows when a queued tag is read from the tag store
// the next event is accepted in the cycle after the result is loaded into the output register
// reset clears the pointer table valid bits at once; the tag store is not cleared
// a full output register that is not taken holds the sequencer in lookup, or in tag wait when a tag is read
`include "per_port_droptail_output_queues_unit_defines.svh"

module per_port_droptail_output_queues_unit import ppdq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_state_type        state_ff, state_in;
   req_payload_type       req_ff;
   logic [NODE_W-1:0]     node_addr_ff;
   logic [LIMIT_W-1:0]    queue_limit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     pend_status_ff, pend_status_in;

   logic                  accept;
   logic [PORT_IDX_W-1:0] port_idx;
   logic                  port_ok;
   logic                  is_full;
   logic                  rsp_free;
   ptr_entry_type         ent;
   ptr_entry_type         new_ent;
   ptr_wr_type            ptr_wr;
   rsp_payload_type       res;
   logic                  act;
   logic                  append;
   logic                  need_tag;
   logic [TAG_ADDR_W-1:0] tag_base;
   logic                  tag_wr_en;
   logic                  tag_rd_en;
   logic [TAG_ADDR_W-1:0] tag_wr_addr;
   logic [TAG_ADDR_W-1:0] tag_rd_addr;
   logic [TAG_WIDTH-1:0]  tag_rd_data;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (32'(p) + 32'd1 == 32'(QUEUE_DEPTH)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   ppdq_ptr_table u_ptr_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (PORT_IDX_W'(req_data.next_port)),
      .rd_data (ent),
      .wr      (ptr_wr)
   );

   ppdq_ram #(
      .DEPTH (TAG_DEPTH),
      .WIDTH (TAG_WIDTH)
   ) u_tag_store (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (req_ff.packet_tag),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign port_idx    = PORT_IDX_W'(req_ff.next_port);
   assign port_ok     = 32'(req_ff.next_port) < 32'(NUM_PORTS);
   assign is_full     = (32'(ent.fill) >= 32'(queue_limit_ff)) ||
                        (32'(ent.fill) >= 32'(QUEUE_DEPTH));
   assign tag_base    = TAG_ADDR_W'(port_idx) * TAG_ADDR_W'(QUEUE_DEPTH);
   assign tag_wr_addr = tag_base + TAG_ADDR_W'(ent.tail);
   assign tag_rd_addr = tag_base + TAG_ADDR_W'(ent.head);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff   <= NODE_ADDR_RESET;
         queue_limit_ff <= QUEUE_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NODE_ADDR:   node_addr_ff   <= csr_data[NODE_W-1:0];
            CSR_QUEUE_LIMIT: queue_limit_ff <= csr_data[LIMIT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_data_ff    <= rsp_data_in;
      pend_status_ff <= pend_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      pend_status_in = pend_status_ff;
      new_ent        = ent;
      res            = '0;
      res.status     = STAT_DONE;
      act            = 1'b0;
      append         = 1'b0;
      need_tag       = 1'b0;
      ptr_wr         = '0;
      tag_wr_en      = 1'b0;
      tag_rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            unique case (req_ff.req_type) inside
               REQ_DONE: begin
                  if (port_ok) begin
                     act          = 1'b1;
                     new_ent.busy = 1'b0;
                     if (ent.fill != '0) begin
                        new_ent.head = ptr_inc(ent.head);
                        new_ent.fill = ent.fill - CNT_W'(1);
                        new_ent.busy = 1'b1;
                        need_tag     = 1'b1;
                     end
                  end
               end
               REQ_SEND, REQ_RECV: begin
                  if (req_ff.req_type == REQ_RECV && req_ff.dest_addr == node_addr_ff) begin
                     res.status = STAT_LOCAL;
                  end else if (!port_ok || is_full) begin
                     res.status = STAT_DROPPED;
                  end else begin
                     act          = 1'b1;
                     append       = 1'b1;
                     res.status   = STAT_ACCEPTED;
                     new_ent.tail = ptr_inc(ent.tail);
                     if (ent.busy) begin
                        new_ent.fill = ent.fill + CNT_W'(1);
                     end else if (ent.fill == '0) begin
                        new_ent.head      = ptr_inc(ent.head);
                        new_ent.busy      = 1'b1;
                        res.forward_valid = 1'b1;
                        res.forward_port  = req_ff.next_port;
                        res.forward_tag   = req_ff.packet_tag;
                     end else begin
                        new_ent.head = ptr_inc(ent.head);
                        new_ent.busy = 1'b1;
                        need_tag     = 1'b1;
                     end
                  end
               end
               default: begin
                  res.status = STAT_DONE;
               end
            endcase

            if (need_tag || rsp_free) begin
               ptr_wr.en   = act;
               ptr_wr.addr = port_idx;
               ptr_wr.data = new_ent;
               tag_wr_en   = append;
               tag_rd_en   = need_tag;
               if (need_tag) begin
                  pend_status_in = res.status;
                  state_in       = ST_TAG_WAIT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = res;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_TAG_WAIT: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = pend_status_ff;
               rsp_data_in.forward_valid = 1'b1;
               rsp_data_in.forward_port  = req_ff.next_port;
               rsp_data_in.forward_tag   = tag_rd_data;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PPDQ_ASSERT(a_fwd_status, clock, reset,
      rsp_valid_ff && rsp_data_ff.forward_valid |->
         (rsp_data_ff.status == STAT_ACCEPTED || rsp_data_ff.status == STAT_DONE),
      "forward with a status other than accepted or done")
   `PPDQ_ASSERT(a_idle_no_tag_wait, clock, reset,
      state_ff == ST_IDLE |=> state_ff != ST_TAG_WAIT,
      "tag wait entered without a lookup")
   `PPDQ_NEVER(a_idle_with_backlog, clock, reset,
      ptr_wr.en && ptr_wr.data.fill != '0 && !ptr_wr.data.busy,
      "port left idle with queued tags")

endmodule
